// ===== rtl/jbt_pkg.sv =====
`timescale 1ns / 1ps

package jbt_pkg;

  // One input word: a text byte or the end-of-text marker.
  typedef struct packed {
    logic       operation;
    logic [7:0] text_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] content_byte;
    logic       token_done;
    logic [3:0] token_kind;
    logic [2:0] error_code;
    logic       text_end;
    logic       last;
  } out_word_t;

  // Up to two results caused by one input word travel together in the queue.
  typedef struct packed {
    logic      two;
    out_word_t first;
    out_word_t second;
  } pair_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_INT   = 3'd3,
    MODE_POINT = 3'd4,
    MODE_FRAC  = 3'd5,
    MODE_KW    = 3'd6
  } mode_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [3:0] KIND_STRING   = 4'd0;
  localparam logic [3:0] KIND_DECIMAL  = 4'd1;
  localparam logic [3:0] KIND_NULL     = 4'd2;
  localparam logic [3:0] KIND_COMMA    = 4'd3;
  localparam logic [3:0] KIND_LBRACE   = 4'd4;
  localparam logic [3:0] KIND_RBRACE   = 4'd5;
  localparam logic [3:0] KIND_LBRACKET = 4'd6;
  localparam logic [3:0] KIND_RBRACKET = 4'd7;
  localparam logic [3:0] KIND_COLON    = 4'd8;
  localparam logic [3:0] KIND_INTEGER  = 4'd9;
  localparam logic [3:0] KIND_TRUE     = 4'd10;
  localparam logic [3:0] KIND_FALSE    = 4'd11;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ESCAPE  = 3'd1;
  localparam logic [2:0] ERR_UNTERM  = 3'd2;
  localparam logic [2:0] ERR_POINT   = 3'd3;
  localparam logic [2:0] ERR_KEYWORD = 3'd4;
  localparam logic [2:0] ERR_CHAR    = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_POINT  = 8'h2E;

  // Keyword table: true, false, null (bit order of the match mask).
  localparam logic [2:0] KW_ALL = 3'b111;
  localparam logic [2:0] KW_LEN [3] = '{3'd4, 3'd5, 3'd4};
  localparam logic [3:0] KW_KIND [3] = '{KIND_TRUE, KIND_FALSE, KIND_NULL};

endpackage

// ===== rtl/jbt_front.sv =====
`timescale 1ns / 1ps

module jbt_front import jbt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_word_t word,
  output logic     push,
  output pair_t    pair
);

  mode_t      mode, mode_next;
  logic [2:0] kw_len, kw_len_next;
  logic [2:0] kw_match, kw_match_next;
  logic [2:0] err, err_next;

  logic [7:0] c;
  logic       is_digit, is_alpha;

  // Decode of the byte as if the lexer were between tokens.
  mode_t      i_mode;
  logic       i_emit;
  out_word_t  i_res;
  logic [2:0] i_err;
  logic [2:0] i_match;

  logic       kw_ok;
  logic [3:0] kw_kind;

  logic [1:0] n;
  out_word_t  r0, r1;

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] p);
    logic [39:0] s;
    logic [7:0]  ch;
    case (k)
      2'd0:    s = {"true", 8'h00};
      2'd1:    s = "false";
      default: s = {"null", 8'h00};
    endcase
    case (p)
      3'd0:    ch = s[39:32];
      3'd1:    ch = s[31:24];
      3'd2:    ch = s[23:16];
      3'd3:    ch = s[15:8];
      3'd4:    ch = s[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_feed(logic [2:0] m, logic [2:0] p, logic [7:0] ch);
    logic [2:0] r;
    r = m;
    for (int k = 0; k < 3; k++) begin
      if (!(p < KW_LEN[k]) || kw_char(2'(k), p) != ch) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic out_word_t mk_byte(logic [7:0] b);
    out_word_t w;
    w = '0;
    w.has_byte = 1'b1;
    w.content_byte = b;
    return w;
  endfunction

  function automatic out_word_t mk_done(logic [3:0] kind);
    out_word_t w;
    w = '0;
    w.token_done = 1'b1;
    w.token_kind = kind;
    return w;
  endfunction

  function automatic out_word_t mk_err(logic [2:0] code);
    out_word_t w;
    w = '0;
    w.error_code = code;
    return w;
  endfunction

  assign c        = word.text_byte;
  assign is_digit = c inside {[8'h30:8'h39]};
  assign is_alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};

  // Between-token classification of the current byte.
  always_comb begin
    i_mode  = MODE_IDLE;
    i_emit  = 1'b0;
    i_res   = '0;
    i_err   = ERR_NONE;
    i_match = kw_feed(KW_ALL, 3'd0, c);
    if (c == CH_QUOTE) begin
      i_mode = MODE_STR;
    end else if (is_digit) begin
      i_mode = MODE_INT;
      i_emit = 1'b1;
      i_res  = mk_byte(c);
    end else if (is_alpha) begin
      i_mode = MODE_KW;
    end else begin
      case (c)
        ",": begin i_emit = 1'b1; i_res = mk_done(KIND_COMMA); end
        "{": begin i_emit = 1'b1; i_res = mk_done(KIND_LBRACE); end
        "}": begin i_emit = 1'b1; i_res = mk_done(KIND_RBRACE); end
        "[": begin i_emit = 1'b1; i_res = mk_done(KIND_LBRACKET); end
        "]": begin i_emit = 1'b1; i_res = mk_done(KIND_RBRACKET); end
        ":": begin i_emit = 1'b1; i_res = mk_done(KIND_COLON); end
        8'h20, 8'h09, 8'h0A, 8'h0D: begin
        end
        default: begin
          i_emit = 1'b1;
          i_res  = mk_err(ERR_CHAR);
          i_err  = ERR_CHAR;
        end
      endcase
    end
  end

  // Does the keyword collected so far name one of the three?
  always_comb begin
    kw_ok   = 1'b0;
    kw_kind = KIND_STRING;
    for (int k = 2; k >= 0; k--) begin
      if (kw_match[k] && kw_len == KW_LEN[k]) begin
        kw_ok   = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
  end

  // Next state.
  always_comb begin
    mode_next     = mode;
    kw_len_next   = kw_len;
    kw_match_next = kw_match;
    err_next      = err;
    if (word.operation == OP_END) begin
      mode_next     = MODE_IDLE;
      kw_len_next   = 3'd0;
      kw_match_next = KW_ALL;
      err_next      = ERR_NONE;
    end else if (err == ERR_NONE) begin
      case (mode)
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            mode_next = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end
        end
        MODE_ESC: begin
          mode_next = MODE_STR;
          if (!(c == CH_QUOTE || c == CH_BSLASH || c == "n" || c == "r" ||
                c == "t" || c == "b" || c == "u")) begin
            err_next = ERR_ESCAPE;
          end
        end
        MODE_POINT: begin
          if (is_digit) begin
            mode_next = MODE_FRAC;
          end else begin
            err_next = ERR_POINT;
          end
        end
        MODE_KW: begin
          if (is_alpha) begin
            kw_match_next = kw_feed(kw_match, kw_len, c);
            if (kw_len != 3'd7) begin
              kw_len_next = kw_len + 3'd1;
            end
          end else if (!kw_ok) begin
            err_next = ERR_KEYWORD;
          end else begin
            mode_next = i_mode;
            err_next  = i_err;
            if (is_alpha) begin
              kw_len_next   = 3'd1;
              kw_match_next = i_match;
            end
          end
        end
        default: begin
          // Idle, and the integer or fraction ended by a non-digit.
          if ((mode == MODE_INT || mode == MODE_FRAC) && is_digit) begin
            mode_next = mode;
          end else if (mode == MODE_INT && c == CH_POINT) begin
            mode_next = MODE_POINT;
          end else begin
            mode_next = i_mode;
            err_next  = i_err;
            if (is_alpha) begin
              kw_len_next   = 3'd1;
              kw_match_next = i_match;
            end
          end
        end
      endcase
    end
  end

  // Results of this word.
  always_comb begin
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    if (word.operation == OP_END) begin
      r0 = '0;
      r0.text_end = 1'b1;
      r0.error_code = err;
      n = 2'd1;
      if (err == ERR_NONE) begin
        case (mode)
          MODE_STR, MODE_ESC: r0.error_code = ERR_UNTERM;
          MODE_POINT:         r0.error_code = ERR_POINT;
          MODE_INT, MODE_FRAC, MODE_KW: begin
            if (mode == MODE_KW && !kw_ok) begin
              r0.error_code = ERR_KEYWORD;
            end else begin
              r1 = r0;
              r0 = mk_done(mode == MODE_INT ? KIND_INTEGER :
                           mode == MODE_FRAC ? KIND_DECIMAL : kw_kind);
              n  = 2'd2;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (err == ERR_NONE) begin
      case (mode)
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            n  = 2'd1;
            r0 = mk_done(KIND_STRING);
          end else if (c != CH_BSLASH) begin
            n  = 2'd1;
            r0 = mk_byte(c);
          end
        end
        MODE_ESC: begin
          n = 2'd1;
          case (c)
            CH_QUOTE, CH_BSLASH: r0 = mk_byte(c);
            "n":     r0 = mk_byte(8'h0A);
            "r":     r0 = mk_byte(8'h0D);
            "t":     r0 = mk_byte(8'h09);
            "b":     r0 = mk_byte(8'h08);
            "u": begin
              n  = 2'd2;
              r0 = mk_byte(CH_BSLASH);
              r1 = mk_byte("u");
            end
            default: r0 = mk_err(ERR_ESCAPE);
          endcase
        end
        MODE_POINT: begin
          n  = 2'd1;
          r0 = is_digit ? mk_byte(c) : mk_err(ERR_POINT);
        end
        MODE_INT, MODE_FRAC: begin
          if (is_digit || (mode == MODE_INT && c == CH_POINT)) begin
            n  = 2'd1;
            r0 = mk_byte(c);
          end else begin
            r0 = mk_done(mode == MODE_INT ? KIND_INTEGER : KIND_DECIMAL);
            r1 = i_res;
            n  = i_emit ? 2'd2 : 2'd1;
          end
        end
        MODE_KW: begin
          if (!is_alpha) begin
            if (kw_ok) begin
              r0 = mk_done(kw_kind);
              r1 = i_res;
              n  = i_emit ? 2'd2 : 2'd1;
            end else begin
              n  = 2'd1;
              r0 = mk_err(ERR_KEYWORD);
            end
          end
        end
        default: begin
          r0 = i_res;
          n  = i_emit ? 2'd1 : 2'd0;
        end
      endcase
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign push        = accept && (n != 2'd0);
  assign pair.two    = (n == 2'd2);
  assign pair.first  = r0;
  assign pair.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      kw_len   <= 3'd0;
      kw_match <= KW_ALL;
      err      <= ERR_NONE;
    end else if (accept) begin
      mode     <= mode_next;
      kw_len   <= kw_len_next;
      kw_match <= kw_match_next;
      err      <= err_next;
    end
  end

endmodule

// ===== rtl/jbt_queue.sv =====
`timescale 1ns / 1ps

module jbt_queue import jbt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  pair_t push_pair,
  input  logic  pop,
  output pair_t head,
  output logic  empty,
  output logic  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  pair_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_COUNT);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/jbt_back.sv =====
`timescale 1ns / 1ps

module jbt_back import jbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pair_t     head,
  input  logic      empty,
  output logic      pop,
  output logic      valid,
  input  logic      stall,
  output out_word_t word
);

  logic second;
  logic load;

  // The output register may be refilled when it is empty or being taken.
  assign load = !valid || !stall;
  assign pop  = load && !empty && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      valid <= !empty;
      if (!empty) begin
        second <= head.two && !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      word <= second ? head.second : head.first;
    end
  end

endmodule

// ===== rtl/json_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// A result word is queued when its byte is accepted, then loaded into the output register.
// Throughput: one input word per cycle; each input word gives zero, one or two result
// words, and the output register sends one result word per cycle unless stalled. The
// queue between lexer and output absorbs bursts; input stalls only when it is full.
// Reset (rst, synchronous) returns the lexer to idle with no error and empties the queue.

module json_byte_tokenizer import jbt_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_word_t  byte_word,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_word
);

  logic  accept;
  logic  push;
  pair_t push_pair;
  pair_t head;
  logic  empty, full, pop;

  // The front end takes a word whenever the queue has a free slot. Words that
  // give no result (whitespace, opening string quotes, bytes after an error) at
  // most move the lexer state and occupy no slot.
  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  // Lexer: the mode, keyword progress and sticky error live here, and each word
  // is turned into its pair of results in the same cycle.
  jbt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (byte_word),
    .push   (push),
    .pair   (push_pair)
  );

  // Short queue of result pairs, so the lexer keeps running while the
  // consumer stalls.
  jbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pair (push_pair),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Output stage: splits each pair into single result words in order and
  // holds the current word in a register while the consumer stalls.
  jbt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .valid (result_valid),
    .stall (result_stall),
    .word  (result_word)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import jbt_pkg::*;

  // Generous bound on the run: about 600 words, at most two results each,
  // a long receiver hold and random idling on both sides fit many times over.
  localparam int CYCLE_LIMIT = 200000;

  // Length of the long receiver hold used to fill the block's result queue.
  localparam int HOLD_CYCLES = 300;

  // Marks "no keyword matched" in the predictor; no real kind uses this code.
  localparam logic [3:0] KIND_NONE = 4'hF;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_word_t  byte_word = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_word_t result_word;

  json_byte_tokenizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Lexer predictor. It mirrors the block's state and works out, for every
  // accepted input word, the zero to two result words it must produce.
  // ---------------------------------------------------------------------------

  mode_t      lex_mode;
  logic [2:0] kw_count;      // letters seen in the current keyword, saturates at 7
  logic [2:0] kw_alive;      // bit 0 true, bit 1 false, bit 2 null still possible
  logic [2:0] first_error;   // sticky error code, ERR_NONE while the text is clean

  out_word_t  step_results[$];     // results of the word being predicted
  out_word_t  pending_results[$];  // results predicted but not yet seen
  int         lexed_count = 0;     // accepted words that the lexer did not ignore
  int         mismatches = 0;
  bit         no_gaps = 1'b0;      // when set, neither side idles

  function automatic void reset_lexer();
    lex_mode    = MODE_IDLE;
    kw_count    = 3'd0;
    kw_alive    = KW_ALL;
    first_error = ERR_NONE;
  endfunction

  function automatic void emit(logic has, logic [7:0] value, logic done,
                               logic [3:0] kind, logic [2:0] err, logic fin);
    out_word_t w;
    w.has_byte     = has;
    w.content_byte = value;
    w.token_done   = done;
    w.token_kind   = kind;
    w.error_code   = err;
    w.text_end     = fin;
    w.last         = 1'b0;
    if (step_results.size() < 2) step_results = {step_results, w};
  endfunction

  // An error yields a single bare result and freezes the lexer until end of text.
  function automatic void flag_error(logic [2:0] code);
    first_error = code;
    emit(1'b0, 8'h00, 1'b0, KIND_STRING, code, 1'b0);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] kw_letter(int k, int pos);
    string s;
    s = (k == 0) ? "true" : (k == 1) ? "false" : "null";
    return (pos < s.len()) ? s[pos] : 8'h00;
  endfunction

  function automatic void feed_letter(logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (kw_count >= KW_LEN[k] || kw_letter(k, int'(kw_count)) != c) kw_alive[k] = 1'b0;
    end
    if (kw_count < 3'd7) kw_count++;
  endfunction

  function automatic logic [3:0] matched_kind();
    for (int k = 0; k < 3; k++) begin
      if (kw_alive[k] && kw_count == KW_LEN[k]) return KW_KIND[k];
    end
    return KIND_NONE;
  endfunction

  // A byte seen between tokens, or the byte that just ended a number or keyword.
  function automatic void lex_idle(logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (c == CH_QUOTE) begin
      lex_mode = MODE_STR;
    end else if (is_digit(c)) begin
      lex_mode = MODE_INT;
      emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
    end else if (is_letter(c)) begin
      lex_mode = MODE_KW;
      kw_count = 3'd0;
      kw_alive = KW_ALL;
      feed_letter(c);
    end else if (c == ",") begin
      emit(1'b0, 8'h00, 1'b1, KIND_COMMA, ERR_NONE, 1'b0);
    end else if (c == "{") begin
      emit(1'b0, 8'h00, 1'b1, KIND_LBRACE, ERR_NONE, 1'b0);
    end else if (c == "}") begin
      emit(1'b0, 8'h00, 1'b1, KIND_RBRACE, ERR_NONE, 1'b0);
    end else if (c == "[") begin
      emit(1'b0, 8'h00, 1'b1, KIND_LBRACKET, ERR_NONE, 1'b0);
    end else if (c == "]") begin
      emit(1'b0, 8'h00, 1'b1, KIND_RBRACKET, ERR_NONE, 1'b0);
    end else if (c == ":") begin
      emit(1'b0, 8'h00, 1'b1, KIND_COLON, ERR_NONE, 1'b0);
    end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
      flag_error(ERR_CHAR);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    logic [3:0] kind;
    case (lex_mode)
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          lex_mode = MODE_IDLE;
          emit(1'b0, 8'h00, 1'b1, KIND_STRING, ERR_NONE, 1'b0);
        end else if (c == CH_BSLASH) begin
          lex_mode = MODE_ESC;
        end else begin
          emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        end
      end
      MODE_ESC: begin
        // An escaped backslash goes back to plain string mode like any other escape.
        lex_mode = MODE_STR;
        if (c == CH_QUOTE || c == CH_BSLASH) emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        else if (c == "n") emit(1'b1, CH_LF, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        else if (c == "r") emit(1'b1, CH_CR, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        else if (c == "t") emit(1'b1, CH_TAB, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        else if (c == "b") emit(1'b1, CH_BS, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        else if (c == "u") begin
          // A unicode escape is passed on untouched as backslash and u.
          emit(1'b1, CH_BSLASH, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
          emit(1'b1, "u", 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        end else flag_error(ERR_ESCAPE);
      end
      MODE_INT: begin
        if (is_digit(c)) begin
          emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        end else if (c == CH_POINT) begin
          lex_mode = MODE_POINT;
          emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        end else begin
          emit(1'b0, 8'h00, 1'b1, KIND_INTEGER, ERR_NONE, 1'b0);
          lex_idle(c);
        end
      end
      MODE_POINT: begin
        if (is_digit(c)) begin
          lex_mode = MODE_FRAC;
          emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        end else flag_error(ERR_POINT);
      end
      MODE_FRAC: begin
        // A second point ends the decimal and then counts as an unknown character.
        if (is_digit(c)) begin
          emit(1'b1, c, 1'b0, KIND_STRING, ERR_NONE, 1'b0);
        end else begin
          emit(1'b0, 8'h00, 1'b1, KIND_DECIMAL, ERR_NONE, 1'b0);
          lex_idle(c);
        end
      end
      MODE_KW: begin
        if (is_letter(c)) begin
          feed_letter(c);
        end else begin
          kind = matched_kind();
          if (kind == KIND_NONE) flag_error(ERR_KEYWORD);
          else begin
            emit(1'b0, 8'h00, 1'b1, kind, ERR_NONE, 1'b0);
            lex_idle(c);
          end
        end
      end
      default: lex_idle(c);
    endcase
  endfunction

  // End of text: flush a pending token, then report the final status.
  function automatic void lex_end();
    logic [2:0] err;
    logic [3:0] kind;
    err = first_error;
    if (err == ERR_NONE) begin
      case (lex_mode)
        MODE_STR, MODE_ESC: err = ERR_UNTERM;
        MODE_INT: emit(1'b0, 8'h00, 1'b1, KIND_INTEGER, ERR_NONE, 1'b0);
        MODE_POINT: err = ERR_POINT;
        MODE_FRAC: emit(1'b0, 8'h00, 1'b1, KIND_DECIMAL, ERR_NONE, 1'b0);
        MODE_KW: begin
          kind = matched_kind();
          if (kind == KIND_NONE) err = ERR_KEYWORD;
          else emit(1'b0, 8'h00, 1'b1, kind, ERR_NONE, 1'b0);
        end
        default: ;
      endcase
    end
    emit(1'b0, 8'h00, 1'b0, KIND_STRING, err, 1'b1);
  endfunction

  function automatic void predict(in_word_t w);
    out_word_t r;
    step_results.delete();
    if (w.operation == OP_END) begin
      lexed_count++;
      lex_end();
      reset_lexer();
    end else if (first_error == ERR_NONE) begin
      lexed_count++;
      lex_byte(w.text_byte);
    end
    // The final result of each input word carries the last flag.
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      if (i == step_results.size() - 1) r.last = 1'b1;
      pending_results = {pending_results, r};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. One word is offered per call; valid stays high across
  // back-to-back words and only drops for a random idle gap.
  // ---------------------------------------------------------------------------

  task automatic send_word(logic op, logic [7:0] value);
    in_word_t w;
    w.operation = op;
    w.text_byte = value;
    while (!no_gaps && $urandom_range(99) < 10) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= w;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i]);
  endtask

  // The byte field is ignored with end of text, so it carries random bits.
  task automatic send_end();
    send_word(OP_END, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The receiver stalls at random, holds off completely while a
  // long hold is active, and never stalls during the steady stretch.
  // ---------------------------------------------------------------------------

  event hold_go;
  logic hold_active = 1'b0;

  always begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else if (hold_active) result_stall <= 1'b1;
    else if (no_gaps) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < 10);
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result word with none expected, expected nothing, actual %h",
                 $time, result_word);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("has_byte", 8'(want.has_byte), 8'(result_word.has_byte));
        check_field("content_byte", want.content_byte, result_word.content_byte);
        check_field("token_done", 8'(want.token_done), 8'(result_word.token_done));
        check_field("token_kind", 8'(want.token_kind), 8'(result_word.token_kind));
        check_field("error_code", 8'(want.error_code), 8'(result_word.error_code));
        check_field("text_end", 8'(want.text_end), 8'(result_word.text_end));
        check_field("last", 8'(want.last), 8'(result_word.last));
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // An open bracket, an integer ended by a comma, a string holding an escaped
  // backslash followed by a unicode escape, a colon, and null ended by a brace.
  task automatic test_structure();
    send_text("[7,\"\\\\\\u\":null}");
    send_end();
  endtask

  // A second point after fraction digits, a trailing point at end of text,
  // and a trailing point followed by a letter.
  task automatic test_numbers();
    send_text("0.9.");
    send_end();
    send_text("3.");
    send_end();
    send_text("2.x");
    send_end();
  endtask

  // A high byte between tokens is an unknown character; the zero byte after it
  // must be ignored. Then a string cut off right after a backslash.
  task automatic test_error_bytes();
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_end();
    send_text("\"\\");
    send_end();
  endtask

  // A keyword prefix that is still open when the text ends.
  task automatic test_keyword_at_end();
    send_text("nul");
    send_end();
  endtask

  task automatic send_random_string();
    string esc_set;
    logic [7:0] c;
    int r;
    esc_set = "\"\\nrtbux";
    send_word(OP_BYTE, CH_QUOTE);
    repeat ($urandom_range(6)) begin
      r = $urandom_range(9);
      if (r < 6) begin
        do c = 8'($urandom_range(8'h7E, 8'h20));
        while (c == CH_QUOTE || c == CH_BSLASH);
        send_word(OP_BYTE, c);
      end else if (r < 8) begin
        send_word(OP_BYTE, CH_BSLASH);
        send_word(OP_BYTE, esc_set[$urandom_range(7)]);
      end else if (r == 8) begin
        send_word(OP_BYTE, 8'($urandom_range(255, 128)));
      end else begin
        send_word(OP_BYTE, 8'($urandom_range(31)));
      end
    end
    if ($urandom_range(19) != 0) send_word(OP_BYTE, CH_QUOTE);
  endtask

  task automatic send_random_number(bit with_point);
    repeat ($urandom_range(4, 1)) send_word(OP_BYTE, CH_ZERO + 8'($urandom_range(9)));
    if (with_point) begin
      send_word(OP_BYTE, CH_POINT);
      // Now and then the point is left without a digit.
      if ($urandom_range(9) != 0)
        repeat ($urandom_range(3, 1)) send_word(OP_BYTE, CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic send_random_keyword();
    int pick;
    pick = $urandom_range(19);
    if (pick < 6) send_text("true");
    else if (pick < 12) send_text("false");
    else if (pick < 17) send_text("null");
    else begin
      // Letters of either case, up to nine, at times enough to saturate the letter count.
      repeat ($urandom_range(9, 1))
        send_word(OP_BYTE, 8'($urandom_range(25)) + ($urandom_range(1) ? "a" : "A"));
    end
  endtask

  // Mostly well-formed tokens with random content; some noise bytes, and an
  // end of text now and then. Once an error has frozen the lexer, the text is
  // soon ended so that most words reach the lexer.
  task automatic send_random_token();
    string punct;
    string space;
    int pick;
    punct = ",{}[]:";
    space = " \t\n\r";
    pick = $urandom_range(99);
    if (first_error != ERR_NONE && $urandom_range(1)) send_end();
    else if (pick < 4) send_end();
    else if (pick < 7) send_word(OP_BYTE, 8'($urandom_range(255)));
    else if (pick < 25) send_word(OP_BYTE, punct[$urandom_range(5)]);
    else if (pick < 35) send_word(OP_BYTE, space[$urandom_range(3)]);
    else if (pick < 60) send_random_string();
    else if (pick < 72) send_random_number(1'b0);
    else if (pick < 82) send_random_number(1'b1);
    else send_random_keyword();
  endtask

  task automatic test_random_text(int count);
    int start;
    start = lexed_count;
    while (lexed_count - start < count) send_random_token();
  endtask

  // Same traffic with neither side idling at all.
  task automatic test_steady_stream(int count);
    no_gaps = 1'b1;
    test_random_text(count);
    no_gaps = 1'b0;
  endtask

  // The receiver holds off for a long stretch while a long string streams in,
  // so the result queue fills and the block must stall its input.
  task automatic test_backpressure();
    -> hold_go;
    send_word(OP_BYTE, CH_QUOTE);
    repeat (40) send_word(OP_BYTE, 8'($urandom_range(25)) + "a");
    send_word(OP_BYTE, CH_QUOTE);
  endtask

  initial begin
    reset_lexer();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_structure();
    test_numbers();
    test_error_bytes();
    test_keyword_at_end();
    test_random_text(200);
    test_steady_stream(150);
    test_backpressure();
    test_random_text(150);

    // Valid drops in the step of the last acceptance; then drain the results.
    byte_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
